@@ rtl/core/fvt_pkg.sv @@
package fvt_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int REG_COUNT   = 6;
  localparam int PLANE_W     = 64;
  localparam int NORM_W      = 12;
  localparam int OFS_W       = 28;
  localparam int COORD_W     = 24;
  localparam int RAD_W       = 23;
  localparam int PROD_W      = NORM_W + COORD_W;
  localparam int DIST_W      = 40;
  localparam int FRAC_SHIFT  = 10;
  localparam int AXES        = 3;
  localparam int ADDR_W      = 6;
  localparam int REG_LSB     = 3;
  localparam int IDX_W       = ADDR_W - REG_LSB;
  localparam int PIPE_LAT    = 4;

  typedef enum logic [1:0] {
    CMD_POINT  = 2'd0,
    CMD_SPHERE = 2'd1,
    CMD_BOX    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic signed [OFS_W-1:0]   ofs_t;
  typedef logic [PLANE_W-1:0]        plane_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    logic valid;
    logic none;
  } ctl_t;

  function automatic norm_t plane_norm(plane_t p, int axis);
    return p[axis*NORM_W +: NORM_W];
  endfunction

  function automatic logic norm_neg(plane_t p, int axis);
    return p[axis*NORM_W + NORM_W - 1];
  endfunction

  function automatic ofs_t plane_ofs(plane_t p);
    return p[PLANE_W-1 -: OFS_W];
  endfunction

endpackage

@@ rtl/core/frustum_visibility_test_top.sv @@
// Frustum visibility test. Each request tests a point, a sphere or an
// axis-aligned box against the six planes held in the configuration
// registers and returns one visible flag. The block takes a request in every
// cycle (busy stays low) and presents its result on out_valid/out_visible
// through four register stages: vertex selection, the normal-by-coordinate
// multipliers, the distance adder and the final AND across the planes. The
// receiver cannot stall, so the result strobe lasts one cycle. Planes are
// written through the APB port at byte address 8*i and must only be changed
// while no request is in flight.
module frustum_visibility_test_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fvt_pkg::ADDR_W-1:0]          paddr,
  input  logic [fvt_pkg::PLANE_W-1:0]         pwdata,
  output logic [fvt_pkg::PLANE_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_command,
  input  logic signed [fvt_pkg::COORD_W-1:0]  in_first_x,
  input  logic signed [fvt_pkg::COORD_W-1:0]  in_first_y,
  input  logic signed [fvt_pkg::COORD_W-1:0]  in_first_z,
  input  logic signed [fvt_pkg::COORD_W-1:0]  in_second_x,
  input  logic signed [fvt_pkg::COORD_W-1:0]  in_second_y,
  input  logic signed [fvt_pkg::COORD_W-1:0]  in_second_z,
  input  logic [fvt_pkg::RAD_W-1:0]           in_radius,
  output logic                                out_valid,
  output logic                                out_visible
);

  fvt_pkg::plane_t                               plane_r [fvt_pkg::REG_COUNT];
  fvt_pkg::plane_t [fvt_pkg::PLANE_COUNT-1:0]    planes;
  logic [fvt_pkg::IDX_W-1:0]                     reg_idx;
  logic                                          cfg_wr;
  logic                                          accept;
  fvt_pkg::vec_t                                 first, second;
  fvt_pkg::ctl_t                                 ctl1, ctl2_r, ctl3_r;
  logic [fvt_pkg::RAD_W-1:0]                     radius1;
  fvt_pkg::vec_t [fvt_pkg::PLANE_COUNT-1:0]      vtx1;
  logic [fvt_pkg::PLANE_COUNT-1:0]               pass;
  logic                                          out_valid_r, out_valid_nxt;
  logic                                          out_visible_r, out_visible_nxt;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = paddr[fvt_pkg::ADDR_W-1:fvt_pkg::REG_LSB];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign accept  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fvt_pkg::REG_COUNT; i++) begin
        plane_r[i] <= '0;
      end
    end else if (cfg_wr && (32'(reg_idx) < fvt_pkg::REG_COUNT)) begin
      plane_r[reg_idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (32'(reg_idx) < fvt_pkg::REG_COUNT) begin
      prdata = plane_r[reg_idx];
    end
  end

  // Planes past the register set read as all zero and therefore always pass.
  for (genvar p = 0; p < fvt_pkg::PLANE_COUNT; p++) begin : g_planes
    if (p < fvt_pkg::REG_COUNT) begin : g_reg
      assign planes[p] = plane_r[p];
    end else begin : g_zero
      assign planes[p] = '0;
    end
  end

  assign first  = '{x: in_first_x,  y: in_first_y,  z: in_first_z};
  assign second = '{x: in_second_x, y: in_second_y, z: in_second_z};

  fvt_vsel u_vsel (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .command  (fvt_pkg::cmd_t'(in_command)),
    .first    (first),
    .second   (second),
    .radius   (in_radius),
    .planes   (planes),
    .ctl_o    (ctl1),
    .radius_o (radius1),
    .vtx_o    (vtx1)
  );

  for (genvar p = 0; p < fvt_pkg::PLANE_COUNT; p++) begin : g_plane
    fvt_plane u_plane (
      .clk    (clk),
      .plane  (planes[p]),
      .vtx    (vtx1[p]),
      .radius (radius1),
      .pass_o (pass[p])
    );
  end

  assign out_valid_nxt   = ctl3_r.valid;
  assign out_visible_nxt = ctl3_r.valid && !ctl3_r.none && (&pass);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r        <= '0;
      ctl3_r        <= '0;
      out_valid_r   <= 1'b0;
      out_visible_r <= 1'b0;
    end else begin
      ctl2_r        <= ctl1;
      ctl3_r        <= ctl2_r;
      out_valid_r   <= out_valid_nxt;
      out_visible_r <= out_visible_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

endmodule

@@ rtl/core/fvt_vsel.sv @@
module fvt_vsel (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          accept,
  input  fvt_pkg::cmd_t                                 command,
  input  fvt_pkg::vec_t                                 first,
  input  fvt_pkg::vec_t                                 second,
  input  logic [fvt_pkg::RAD_W-1:0]                     radius,
  input  fvt_pkg::plane_t [fvt_pkg::PLANE_COUNT-1:0]    planes,
  output fvt_pkg::ctl_t                                 ctl_o,
  output logic [fvt_pkg::RAD_W-1:0]                     radius_o,
  output fvt_pkg::vec_t [fvt_pkg::PLANE_COUNT-1:0]      vtx_o
);

  fvt_pkg::ctl_t                             ctl_r, ctl_nxt;
  logic [fvt_pkg::RAD_W-1:0]                 radius_r, radius_nxt;
  fvt_pkg::vec_t [fvt_pkg::PLANE_COUNT-1:0]  vtx_r, vtx_nxt;
  logic                                      is_box;

  assign is_box = (command == fvt_pkg::CMD_BOX);

  // A box is tested at the corner that lies farthest along each plane normal.
  always_comb begin
    for (int p = 0; p < fvt_pkg::PLANE_COUNT; p++) begin
      vtx_nxt[p].x = (is_box && !fvt_pkg::norm_neg(planes[p], 0)) ? second.x : first.x;
      vtx_nxt[p].y = (is_box && !fvt_pkg::norm_neg(planes[p], 1)) ? second.y : first.y;
      vtx_nxt[p].z = (is_box && !fvt_pkg::norm_neg(planes[p], 2)) ? second.z : first.z;
    end
    radius_nxt    = (command == fvt_pkg::CMD_SPHERE) ? radius : '0;
    ctl_nxt.valid = accept;
    ctl_nxt.none  = (command == fvt_pkg::CMD_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    radius_r <= radius_nxt;
    vtx_r    <= vtx_nxt;
  end

  assign ctl_o    = ctl_r;
  assign radius_o = radius_r;
  assign vtx_o    = vtx_r;

endmodule

@@ rtl/core/fvt_plane.sv @@
module fvt_plane (
  input  logic                       clk,
  input  fvt_pkg::plane_t            plane,
  input  fvt_pkg::vec_t              vtx,
  input  logic [fvt_pkg::RAD_W-1:0]  radius,
  output logic                       pass_o
);

  logic signed [fvt_pkg::PROD_W-1:0] prod_x_r, prod_y_r, prod_z_r;
  logic signed [fvt_pkg::DIST_W-1:0] ofs_r, ofs_nxt;
  logic signed [fvt_pkg::DIST_W-1:0] w_ext, r_ext, dist_sum;
  fvt_pkg::norm_t                    nx, ny, nz;
  logic                              pass_r, pass_nxt;

  assign nx    = fvt_pkg::plane_norm(plane, 0);
  assign ny    = fvt_pkg::plane_norm(plane, 1);
  assign nz    = fvt_pkg::plane_norm(plane, 2);
  assign w_ext = fvt_pkg::DIST_W'(fvt_pkg::plane_ofs(plane));
  assign r_ext = $signed({{(fvt_pkg::DIST_W-fvt_pkg::RAD_W){1'b0}}, radius});

  // The sphere radius moves the pass threshold, so it is folded into the offset.
  assign ofs_nxt = (w_ext <<< fvt_pkg::FRAC_SHIFT) + (r_ext <<< fvt_pkg::FRAC_SHIFT);

  assign dist_sum = fvt_pkg::DIST_W'(prod_x_r) + fvt_pkg::DIST_W'(prod_y_r)
                  + fvt_pkg::DIST_W'(prod_z_r) + ofs_r;
  assign pass_nxt = !dist_sum[fvt_pkg::DIST_W-1];

  always_ff @(posedge clk) begin
    prod_x_r <= nx * vtx.x;
    prod_y_r <= ny * vtx.y;
    prod_z_r <= nz * vtx.z;
    ofs_r    <= ofs_nxt;
    pass_r   <= pass_nxt;
  end

  assign pass_o = pass_r;

endmodule

@@ rtl/core/fvt_checker.sv @@
module fvt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_command,
  input logic       out_valid,
  input logic       out_visible
);

  // Every accepted request yields its result at the end of the pipeline.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(fvt_pkg::PIPE_LAT) out_valid)
    else $error("accepted request produced no result");

  // No result appears without a request taken at the matching earlier edge.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, fvt_pkg::PIPE_LAT))
    else $error("result without a matching request");

  // The unused command never reports a visible object.
  a_unused_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == fvt_pkg::CMD_NONE))
      |-> ##(fvt_pkg::PIPE_LAT) (out_valid && !out_visible))
    else $error("unused command reported visible");

  a_quiet_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !out_visible)
    else $error("visible flag set without a result strobe");

endmodule

bind frustum_visibility_test_top fvt_checker u_fvt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_command  (in_command),
  .out_valid   (out_valid),
  .out_visible (out_visible)
);
